### rtl/core/pmz_pkg.sv
// Package for the peptide m/z block: widths, mass constants, residue table, types.
package pmz_pkg;

  // Accumulator width for the running residue sum.
  localparam int ACC_BITS = 34;

  localparam int CODE_W  = 8;
  localparam int DELTA_W = 28;
  localparam int CHG_W   = 4;
  localparam int MZ_W    = 33;
  localparam int STAT_W  = 2;
  localparam int ROM_W   = 25;

  // Sum is formed one bit wider than the wider of accumulator and addend.
  localparam int SUM_W = ((ACC_BITS > DELTA_W) ? ACC_BITS : DELTA_W) + 1;

  // Divider: the dividend is padded to whole 4-bit digits, one digit a cycle.
  localparam int DIG_BITS = 4;
  localparam int DIV_W    = ((ACC_BITS + DIG_BITS - 1) / DIG_BITS) * DIG_BITS;
  localparam int DIV_CYC  = DIV_W / DIG_BITS;
  localparam int CNT_W    = $clog2(DIV_CYC);
  localparam int CMP_W    = (DIV_W > MZ_W) ? DIV_W : MZ_W;

  // Masses in units of 1e-5 Da.
  localparam logic [16:0] MASS_PROTON = 17'd100728;
  localparam logic [20:0] MASS_OXYGEN = 21'd1599491;
  localparam logic [20:0] MASS_WATER  = 21'(2 * 100728 + 1599491);

  localparam logic [MZ_W-1:0] MZ_MAX = '1;

  localparam logic [CODE_W-1:0] CODE_A = 8'h41;
  localparam logic [CODE_W-1:0] CODE_Z = 8'h5A;
  localparam logic [CODE_W-1:0] CODE_X = 8'h58;
  localparam logic [CODE_W-1:0] CODE_L = 8'h4C;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONPOS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_CH = 2'd2;

  localparam int ROM_DEPTH = 26;
  localparam logic [ROM_W-1:0] RESIDUE_ROM [ROM_DEPTH] = '{
    25'd7103711,  25'd0,        25'd10300919, 25'd11502694, 25'd12904259,
    25'd14706841, 25'd5702146,  25'd13705891, 25'd11308406, 25'd0,
    25'd12809496, 25'd11308406, 25'd13104049, 25'd11404293, 25'd0,
    25'd9705276,  25'd12805858, 25'd15610111, 25'd8703203,  25'd10104768,
    25'd0,        25'd9906841,  25'd18607931, 25'd0,        25'd16306333,
    25'd0
  };

  // Monoisotopic residue mass of an ASCII code; X is taken as L.
  function automatic logic [ROM_W-1:0] residue_mass(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] c;
    logic [CODE_W-1:0] off;
    c   = (code == CODE_X) ? CODE_L : code;
    off = c - CODE_A;
    if (c >= CODE_A && c <= CODE_Z) begin
      return RESIDUE_ROM[off[4:0]];
    end
    return '0;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } pmz_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;      // input transaction accepted
    logic calc;      // form the total and the status
    logic div_step;  // one quotient digit
    logic load_out;  // move the result into the output register
  } pmz_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic err;       // sum not positive or zero charge
    logic div_last;  // final quotient digit this cycle
    logic out_free;  // output register can take a result
  } pmz_stat_t;

endpackage

### rtl/core/pmz_if.sv
// Channel interfaces for residue input and m/z result transactions.
interface pmz_in_if;
  import pmz_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CODE_W-1:0]         residue_code;
  logic                      has_mod;
  logic signed [DELTA_W-1:0] mod_delta;
  logic [CHG_W-1:0]          charge;
  logic                      last;

  modport source (output valid, residue_code, has_mod, mod_delta, charge, last,
                  input ready);
  modport sink   (input valid, residue_code, has_mod, mod_delta, charge, last,
                  output ready);
endinterface

interface pmz_out_if;
  import pmz_pkg::*;
  logic              valid;
  logic              ready;
  logic [MZ_W-1:0]   mz;
  logic [STAT_W-1:0] status;

  modport source (output valid, mz, status, input ready);
  modport sink   (input valid, mz, status, output ready);
endinterface

### rtl/core/peptide_mz_from_residues_top.sv
// Top level of the peptide m/z block: controller, datapath and channel hookup.
// A residue that is not final is absorbed in the cycle it is accepted, one per cycle while idle.
// A final residue passes through the total step, the divider (4 bits a digit) and the output
// load, which waits for a free output register; the divider is skipped when the sum is not
// positive or the charge is zero. New residues are taken only once the result is loaded.
// Reset (rst_n low, synchronous): clears the residue sum, the state and the output valid.
module peptide_mz_from_residues_top (
  input  logic      clk,
  input  logic      rst_n,
  pmz_in_if.sink    in_ch,
  pmz_out_if.source out_ch
);
  import pmz_pkg::*;

  pmz_cmd_t  cmd;
  pmz_stat_t stat;
  logic      in_ready;

  // The controller takes input transactions only while idle; residues that are not
  // final stream at full rate; a final one starts the total step, then divide unless in error.
  pmz_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // The datapath owns the accumulator, the divider and the output register. The
  // output register lets new residues flow in while a finished result waits.
  pmz_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_residue_code (in_ch.residue_code),
    .in_has_mod      (in_ch.has_mod),
    .in_mod_delta    (in_ch.mod_delta),
    .in_charge       (in_ch.charge),
    .in_last         (in_ch.last),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_mz          (out_ch.mz),
    .out_status      (out_ch.status)
  );

endmodule

### rtl/core/pmz_dp.sv
// Datapath: saturating residue accumulator, total formation, digit divider, output register.
module pmz_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pmz_pkg::pmz_cmd_t                  cmd,
  output pmz_pkg::pmz_stat_t                 stat,
  input  logic [pmz_pkg::CODE_W-1:0]         in_residue_code,
  input  logic                               in_has_mod,
  input  logic signed [pmz_pkg::DELTA_W-1:0] in_mod_delta,
  input  logic [pmz_pkg::CHG_W-1:0]          in_charge,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pmz_pkg::MZ_W-1:0]           out_mz,
  output logic [pmz_pkg::STAT_W-1:0]         out_status
);
  import pmz_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (ACC_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [ACC_BITS-1:0] acc_r, acc_nxt;
  logic signed [ACC_BITS-1:0] fin_r, fin_nxt;
  logic [CHG_W-1:0]           charge_r, charge_nxt;
  logic [STAT_W-1:0]          status_r, status_nxt;
  logic [DIV_W-1:0]           quo_r, quo_nxt;
  logic [CHG_W-1:0]           rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [MZ_W-1:0]            out_mz_r, out_mz_nxt;
  logic [STAT_W-1:0]          out_status_r, out_status_nxt;

  logic signed [SUM_W-1:0]    addend;
  logic signed [SUM_W-1:0]    sum_raw;
  logic signed [ACC_BITS-1:0] sum_sat;
  logic [DIV_W-1:0]           total;
  logic [CHG_W:0]             r5;
  logic [CHG_W-1:0]           r_step;
  logic [DIV_W-1:0]           q_step;
  logic                       err;

  // Saturating accumulate of the table mass or the modified mass.
  always_comb begin
    addend  = in_has_mod ? SUM_W'(in_mod_delta)
                         : $signed({{(SUM_W-ROM_W){1'b0}}, residue_mass(in_residue_code)});
    sum_raw = SUM_W'(acc_r) + addend;
    if (sum_raw > SAT_HI) begin
      sum_sat = ACC_BITS'(SAT_HI);
    end else if (sum_raw < SAT_LO) begin
      sum_sat = ACC_BITS'(SAT_LO);
    end else begin
      sum_sat = ACC_BITS'(sum_raw);
    end
  end

  // Final sum is positive when used, so its magnitude fits ACC_BITS-1 bits.
  assign total = DIV_W'(fin_r[ACC_BITS-2:0]) + DIV_W'(MASS_WATER)
               + DIV_W'(charge_r) * DIV_W'(MASS_PROTON);

  assign err = (fin_r <= 0) || (charge_r == '0);

  // Restoring division, four quotient bits per cycle.
  always_comb begin
    r_step = rem_r;
    q_step = quo_r;
    r5     = '0;
    for (int i = 0; i < DIG_BITS; i++) begin
      r5     = {r_step, q_step[DIV_W-1]};
      q_step = {q_step[DIV_W-2:0], 1'b0};
      if (r5 >= {1'b0, charge_r}) begin
        r5        = r5 - {1'b0, charge_r};
        q_step[0] = 1'b1;
      end
      r_step = r5[CHG_W-1:0];
    end
  end

  always_comb begin
    acc_nxt        = acc_r;
    fin_nxt        = fin_r;
    charge_nxt     = charge_r;
    status_nxt     = status_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_mz_nxt     = out_mz_r;
    out_status_nxt = out_status_r;

    if (cmd.take) begin
      if (in_last) begin
        fin_nxt    = sum_sat;
        charge_nxt = in_charge;
        acc_nxt    = '0;
      end else begin
        acc_nxt = sum_sat;
      end
    end

    if (cmd.calc) begin
      priority if (fin_r <= 0) begin
        status_nxt = ST_NONPOS;
      end else if (charge_r == '0) begin
        status_nxt = ST_ZERO_CH;
      end else begin
        status_nxt = ST_OK;
      end
      quo_nxt = total;
      rem_nxt = '0;
      cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      quo_nxt = q_step;
      rem_nxt = r_step;
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (cmd.load_out) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      if (status_r != ST_OK) begin
        out_mz_nxt = '0;
      end else if (CMP_W'(quo_r) > CMP_W'(MZ_MAX)) begin
        out_mz_nxt = MZ_MAX;
      end else begin
        out_mz_nxt = MZ_W'(quo_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r        <= fin_nxt;
    charge_r     <= charge_nxt;
    status_r     <= status_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    out_mz_r     <= out_mz_nxt;
    out_status_r <= out_status_nxt;
  end

  assign stat.err      = err;
  assign stat.div_last = (cnt_r == CNT_W'(DIV_CYC - 1));
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_mz     = out_mz_r;
  assign out_status = out_status_r;

  // The accumulator is clear right after a peptide's final residue.
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && in_last) |=> (acc_r == '0))
    else $error("accumulator not cleared after final residue");

  // An error result never carries an m/z value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_mz_r == '0))
    else $error("error result with nonzero m/z");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule

### rtl/core/pmz_ctrl.sv
// Controller state machine sequencing accumulate, total, divide and result load.
module pmz_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  pmz_pkg::pmz_stat_t  stat,
  output pmz_pkg::pmz_cmd_t   cmd
);
  import pmz_pkg::*;

  pmz_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_last) begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = stat.err ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The divider runs its full digit count.
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !stat.div_last) |=> (state_r == ST_DIV))
    else $error("divider left early");

  // An error peptide skips the divider.
  a_err_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC && stat.err) |=> (state_r == ST_OUT))
    else $error("error case entered divider");

  // A pending result waits while the output is full.
  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !stat.out_free) |=> (state_r == ST_OUT))
    else $error("result dropped while output full");

endmodule

### sim/peptide_mz_from_residues_top_test.sv
// Self-checking testbench for the peptide m/z block: directed and random peptides, scored in order.
`timescale 1ns / 1ps

module peptide_mz_from_residues_top_test;
  import pmz_pkg::*;

  // A cycle with no transaction on either channel counts toward this limit. The worst
  // correct gap is one long sender pause, the divider latency and one long result stall.
  localparam int QUIET_LIMIT = 2000;

  // Cycles allowed after the last expected result for anything stray to show up.
  localparam int DRAIN_CYCLES = 16;

  // How many random residues the random phase sends.
  localparam int RANDOM_RESIDUES = 900;

  // Masses in units of 1e-5 Da.
  localparam longint PROTON_MASS = 100728;
  localparam longint OXYGEN_MASS = 1599491;
  localparam longint WATER_MASS  = 2 * PROTON_MASS + OXYGEN_MASS;

  // Rails of the running residue sum.
  localparam longint SUM_MAX = (longint'(1) <<< (ACC_BITS - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  // Largest and smallest modified residue masses that the input field can carry.
  localparam logic signed [DELTA_W-1:0] DELTA_TOP    = {1'b0, {(DELTA_W - 1){1'b1}}};
  localparam logic signed [DELTA_W-1:0] DELTA_BOTTOM = {1'b1, {(DELTA_W - 1){1'b0}}};

  typedef struct {
    logic [CODE_W-1:0]         code;
    logic                      has_mod;
    logic signed [DELTA_W-1:0] delta;
    logic [CHG_W-1:0]          charge;
    logic                      last;
  } residue_t;

  typedef struct {
    logic [MZ_W-1:0]   mz;
    logic [STAT_W-1:0] status;
  } mz_result_t;

  logic clk;
  logic rst_n;

  pmz_in_if  in_ch ();
  pmz_out_if out_ch ();

  peptide_mz_from_residues_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Running residue sum of the peptide being sent, as the block should hold it.
  longint peptide_sum;

  // m/z results that accepted peptides still owe, oldest first.
  mz_result_t expected_mz [$];

  // Idle controls; a test sets its own mix or keeps the one before, so that gaps land on every phase.
  bit in_gaps_on;
  bit out_stalls_on;

  int error_count;
  int residues_sent;
  int peptides_sent;
  int results_checked;
  int status_seen [4];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monoisotopic residue mass by letter; letters without a residue and all other codes weigh
  // nothing. X is read as L.
  function automatic longint letter_mass(input logic [CODE_W-1:0] code);
    case (code)
      "A": return 7103711;
      "C": return 10300919;
      "D": return 11502694;
      "E": return 12904259;
      "F": return 14706841;
      "G": return 5702146;
      "H": return 13705891;
      "I": return 11308406;
      "K": return 12809496;
      "L": return 11308406;
      "M": return 13104049;
      "N": return 11404293;
      "P": return 9705276;
      "Q": return 12805858;
      "R": return 15610111;
      "S": return 8703203;
      "T": return 10104768;
      "V": return 9906841;
      "W": return 18607931;
      "X": return 11308406;
      "Y": return 16306333;
      default: return 0;
    endcase
  endfunction

  // Adds one accepted residue to the running sum and, on the final residue of a peptide,
  // queues the m/z result that it owes.
  function automatic void accumulate_residue(input residue_t r);
    longint     addend;
    longint     total;
    longint     quotient;
    mz_result_t res;
    addend = r.has_mod ? longint'(r.delta) : letter_mass(r.code);
    peptide_sum = peptide_sum + addend;
    if (peptide_sum > SUM_MAX) begin
      peptide_sum = SUM_MAX;
    end else if (peptide_sum < SUM_MIN) begin
      peptide_sum = SUM_MIN;
    end
    if (!r.last) begin
      return;
    end
    // A sum that is not positive wins over a zero charge.
    if (peptide_sum <= 0) begin
      res.mz     = '0;
      res.status = ST_NONPOS;
    end else if (r.charge == 0) begin
      res.mz     = '0;
      res.status = ST_ZERO_CH;
    end else begin
      total    = peptide_sum + WATER_MASS + longint'(r.charge) * PROTON_MASS;
      quotient = total / longint'(r.charge);
      res.mz     = (quotient > longint'(MZ_MAX)) ? MZ_MAX : quotient[MZ_W-1:0];
      res.status = ST_OK;
    end
    expected_mz = {expected_mz, res};
    peptide_sum = 0;
  endfunction

  // Idle stretch length: mostly short, now and then long.
  function automatic int pick_idle_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic residue_t make_residue(input logic [CODE_W-1:0] code,
                                            input logic has_mod,
                                            input logic signed [DELTA_W-1:0] delta,
                                            input logic [CHG_W-1:0] charge,
                                            input logic last);
    residue_t r;
    r.code    = code;
    r.has_mod = has_mod;
    r.delta   = delta;
    r.charge  = charge;
    r.last    = last;
    return r;
  endfunction

  // Sends one residue transaction. The payload changes at a falling edge; the residue counts
  // as accepted at the first rising edge that sees ready high.
  task automatic send_residue(input residue_t r);
    int gap;
    gap = (in_gaps_on && $urandom_range(0, 99) < 40) ? pick_idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.residue_code <= r.code;
    in_ch.has_mod      <= r.has_mod;
    in_ch.mod_delta    <= r.delta;
    in_ch.charge       <= r.charge;
    in_ch.last         <= r.last;
    do @(posedge clk); while (!in_ch.ready);
    accumulate_residue(r);
    residues_sent++;
    if (r.last) begin
      peptides_sent++;
    end
  endtask

  // Sends a peptide written as plain letters; the charge rides on the final residue, while
  // the others carry a random charge that the block must ignore.
  task automatic send_peptide_string(input string letters, input logic [CHG_W-1:0] charge);
    bit is_last;
    for (int i = 0; i < letters.len(); i++) begin
      is_last = (i == letters.len() - 1);
      send_residue(make_residue(letters[i], 1'b0, '0,
                                is_last ? charge : CHG_W'($urandom()), is_last));
    end
  endtask

  // Sends n_first modified residues of delta_first, then n_second of delta_second; the
  // codes are random since the modification replaces the table mass.
  task automatic send_rail_peptide(input int n_first,
                                   input logic signed [DELTA_W-1:0] delta_first,
                                   input int n_second,
                                   input logic signed [DELTA_W-1:0] delta_second,
                                   input logic [CHG_W-1:0] charge);
    int  n_total;
    bit  is_last;
    n_total = n_first + n_second;
    for (int i = 0; i < n_total; i++) begin
      is_last = (i == n_total - 1);
      send_residue(make_residue(CODE_W'($urandom()), 1'b1,
                                (i < n_first) ? delta_first : delta_second,
                                is_last ? charge : CHG_W'($urandom()), is_last));
    end
  endtask

  // One random residue: mostly real letters, some X, some arbitrary bytes, a few modified.
  function automatic residue_t random_residue(input bit is_last);
    residue_t    r;
    int          pick;
    logic [31:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      r.code = CODE_A + CODE_W'($urandom_range(0, 25));
    end else if (pick < 80) begin
      r.code = CODE_X;
    end else begin
      r.code = CODE_W'($urandom_range(0, 255));
    end
    r.has_mod = ($urandom_range(0, 99) < 15);
    raw = $urandom();
    case ($urandom_range(0, 3))
      0, 1: r.delta = DELTA_W'($urandom_range(0, 30000000));
      2:    r.delta = DELTA_W'(int'($urandom_range(0, 60000000)) - 30000000);
      default: r.delta = raw[DELTA_W-1:0];
    endcase
    if (is_last && $urandom_range(0, 99) < 85) begin
      r.charge = CHG_W'($urandom_range(1, 4));
    end else begin
      r.charge = CHG_W'($urandom_range(0, 15));
    end
    r.last = is_last;
    return r;
  endfunction

  // Letters, X as L, and the charge extremes.
  task automatic test_letter_masses();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    send_peptide_string("GX", 4'd1);
    send_peptide_string("PEPTIDE", 4'd15);
    // A positive sum with no charge must report the zero charge status.
    send_peptide_string("W", 4'd0);
  endtask

  // Codes that weigh nothing: lowercase, an unused letter, punctuation and the byte extremes.
  // The sum stays at zero, which counts as not positive.
  task automatic test_massless_codes();
    send_residue(make_residue("b", 1'b0, '0, 4'd9, 1'b0));
    send_residue(make_residue("J", 1'b0, '0, 4'd0, 1'b0));
    send_residue(make_residue("@", 1'b0, '0, 4'd5, 1'b0));
    send_residue(make_residue(8'h00, 1'b0, '0, 4'd15, 1'b0));
    send_residue(make_residue(8'hFF, 1'b0, '0, 4'd3, 1'b1));
  endtask

  // Modified residues replace the table mass, including negative deltas.
  task automatic test_modified_residues();
    send_residue(make_residue("W", 1'b1, DELTA_TOP, 4'd2, 1'b0));
    send_residue(make_residue("A", 1'b0, '0, 4'd0, 1'b0));
    send_residue(make_residue("K", 1'b1, -28'sd1, 4'd1, 1'b1));
    // Alanine cancelled exactly: a zero sum is not positive.
    send_residue(make_residue("A", 1'b0, '0, 4'd6, 1'b0));
    send_residue(make_residue("A", 1'b1, -28'sd7103711, 4'd5, 1'b1));
    // Negative sum with a zero charge: the charge is not looked at.
    send_residue(make_residue("C", 1'b1, DELTA_BOTTOM, 4'd0, 1'b1));
  endtask

  // Long runs of extreme deltas drive the sum into both rails. Each peptide ends at a point
  // whose result differs if the rail was not held.
  task automatic test_sum_saturation();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b1;
    // Held at the upper rail with charge 1: the m/z clamps too.
    send_rail_peptide(70, DELTA_TOP, 0, DELTA_TOP, 4'd1);
    // One step down from the upper rail.
    send_rail_peptide(70, DELTA_TOP, 1, DELTA_BOTTOM, 4'd1);
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b0;
    // Climbing back from the lower rail ends positive only if the rail held.
    send_rail_peptide(70, DELTA_BOTTOM, 66, DELTA_TOP, 4'd2);
    send_rail_peptide(70, DELTA_BOTTOM, 0, DELTA_TOP, 4'd7);
  endtask

  // Random peptides, mostly short and some long, under changing idle patterns.
  task automatic test_random_peptides();
    int stop_at;
    int len;
    int pick;
    stop_at = residues_sent + RANDOM_RESIDUES;
    while (residues_sent < stop_at) begin
      if (peptides_sent % 16 == 0) begin
        pick          = $urandom_range(0, 3);
        in_gaps_on    = pick[0];
        out_stalls_on = pick[1];
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = $urandom_range(1, 8);
      end else if (pick < 95) begin
        len = $urandom_range(9, 30);
      end else begin
        len = $urandom_range(31, 80);
      end
      for (int i = 0; i < len; i++) begin
        send_residue(random_residue(i == len - 1));
      end
    end
  endtask

  // Result side: ready is driven at falling edges, with random stall stretches when enabled.
  initial begin : result_ready_driver
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (rst_n && out_stalls_on && $urandom_range(0, 99) < 30) begin
        out_ch.ready <= 1'b0;
        stall_left = pick_idle_len() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every result transaction is scored against the oldest outstanding expectation.
  always @(posedge clk) begin : score_results
    mz_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_mz.size() == 0) begin
        $error("result with none outstanding: mz %0d, status %0d", out_ch.mz, out_ch.status);
        error_count++;
      end else begin
        want = expected_mz.pop_front();
        if (out_ch.mz !== want.mz) begin
          $error("mz mismatch: expected %0d, actual %0d", want.mz, out_ch.mz);
          error_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
          error_count++;
        end
        status_seen[want.status]++;
        results_checked++;
      end
    end
  end

  // Ends the run if neither channel moves a transaction for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
             quiet, expected_mz.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : run_tests
    // Every input known from time zero; reset held low first, then released for good at a falling edge.
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.residue_code = '0;
    in_ch.has_mod      = 1'b0;
    in_ch.mod_delta    = '0;
    in_ch.charge       = '0;
    in_ch.last         = 1'b0;
    in_gaps_on         = 1'b0;
    out_stalls_on      = 1'b0;
    peptide_sum        = 0;
    error_count        = 0;
    residues_sent      = 0;
    peptides_sent      = 0;
    results_checked    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_letter_masses();
    test_massless_codes();
    test_modified_residues();
    test_sum_saturation();
    test_random_peptides();

    // Stop sending, let every owed result arrive, then watch a little longer for strays.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_mz.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d residues in %0d peptides; scored %0d results.",
             residues_sent, peptides_sent, results_checked);
    $display("Outcomes: %0d m/z values, %0d non-positive sums, %0d zero charges.",
             status_seen[ST_OK], status_seen[ST_NONPOS], status_seen[ST_ZERO_CH]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
